FILE: sv/trcc_pkg.sv
`timescale 1ns / 1ps
package trcc_pkg;

    localparam int POS_W = 4;

    localparam logic [15:0] CRC_POLY = 16'h8408;
    localparam logic [15:0] CRC_INIT = 16'h0000;
    localparam logic [7:0]  DELIM_RESET = 8'h7E;

    typedef enum logic [1:0] {
        ST_NO_TAG   = 2'd0,
        ST_BAD_DELIM = 2'd1,
        ST_CRC_OK   = 2'd2,
        ST_CRC_BAD  = 2'd3
    } t_status;

    typedef logic [POS_W-1:0] t_pos;

endpackage

FILE: sv/trcc_crc_byte.sv
`timescale 1ns / 1ps
module trcc_crc_byte
    import trcc_pkg::*;
(
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);

    // reflected CRC-16, one byte, LSB first
    always_comb begin
        logic [15:0] c;
        c = i_crc ^ {8'h00, i_byte};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        o_crc = c;
    end

endmodule

FILE: sv/transponder_frame_crc_check.sv
`timescale 1ns / 1ps
// The result is registered and shows on o_valid in the cycle after the stop-delimiter beat.
// Throughput: one byte per cycle; the byte path stalls only while a result
// is held in the output register and the receiver stalls it.
// The CRC byte update is one unrolled eight-bit step between the frame state
// registers. Reset (synchronous, active low) clears the frame position and
// output valid and sets the delimiter register to 0x7E.
module transponder_frame_crc_check
    import trcc_pkg::*;
#(
    parameter int ID_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_frame_first,
    // result output
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [63:0] o_tag_id,
    output logic [15:0] o_crc_computed,
    // delimiter register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    localparam t_pos POS_LOW  = t_pos'(ID_BYTES + 1);
    localparam t_pos POS_HIGH = t_pos'(ID_BYTES + 2);
    localparam t_pos POS_LAST = t_pos'(ID_BYTES);

    logic [7:0]  r_delim;
    t_pos        r_pos,  n_pos;
    logic [15:0] r_crc,  n_crc;
    logic [63:0] r_id,   n_id;
    logic [7:0]  r_start, n_start;
    logic [7:0]  r_crc_lo, n_crc_lo;
    logic [7:0]  r_crc_hi, n_crc_hi;

    logic        r_out_valid, n_out_valid;
    t_status     r_status, n_status;
    logic [63:0] r_out_id, n_out_id;
    logic [15:0] r_out_crc, n_out_crc;

    logic        in_fire;
    logic        out_take;
    logic        stop_fire;
    t_pos        pos;
    logic [15:0] crc_upd;

    assign o_stall     = r_out_valid & i_stall;
    assign in_fire     = i_valid & ~o_stall;
    assign out_take    = r_out_valid & ~i_stall;
    assign o_cfg_ready = 1'b1;

    assign pos = i_frame_first ? '0 : r_pos;

    trcc_crc_byte u_crc (
        .i_crc  (r_crc),
        .i_byte (i_rx_byte),
        .o_crc  (crc_upd)
    );

    always_comb begin
        n_pos     = r_pos;
        n_crc     = r_crc;
        n_id      = r_id;
        n_start   = r_start;
        n_crc_lo  = r_crc_lo;
        n_crc_hi  = r_crc_hi;
        stop_fire = 1'b0;
        if (in_fire) begin
            if (pos == '0) begin
                n_start = i_rx_byte;
                n_crc   = CRC_INIT;
                n_id    = '0;
                n_pos   = t_pos'(1);
            end else if (pos <= POS_LAST) begin
                for (int k = 0; k < ID_BYTES; k++) begin
                    if (pos == t_pos'(k + 1)) begin
                        n_id[8*k +: 8] = i_rx_byte;
                    end
                end
                n_crc = crc_upd;
                n_pos = pos + t_pos'(1);
            end else if (pos == POS_LOW) begin
                n_crc_lo = i_rx_byte;
                n_pos    = pos + t_pos'(1);
            end else if (pos == POS_HIGH) begin
                n_crc_hi = i_rx_byte;
                n_pos    = pos + t_pos'(1);
            end else begin
                stop_fire = 1'b1;
                n_pos     = '0;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid & ~out_take;
        n_status    = r_status;
        n_out_id    = r_out_id;
        n_out_crc   = r_out_crc;
        if (stop_fire) begin
            n_out_valid = 1'b1;
            n_out_id    = r_id;
            n_out_crc   = r_crc;
            if (r_crc_lo == 8'h00 && r_crc_hi == 8'h00) begin
                n_status = ST_NO_TAG;
            end else if (r_start != r_delim || i_rx_byte != r_delim) begin
                n_status = ST_BAD_DELIM;
            end else if ({r_crc_hi, r_crc_lo} == r_crc) begin
                n_status = ST_CRC_OK;
            end else begin
                n_status = ST_CRC_BAD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim     <= DELIM_RESET;
            r_pos       <= '0;
            r_crc       <= CRC_INIT;
            r_id        <= '0;
            r_start     <= '0;
            r_crc_lo    <= '0;
            r_crc_hi    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_delim <= i_cfg_data;
            end
            r_pos       <= n_pos;
            r_crc       <= n_crc;
            r_id        <= n_id;
            r_start     <= n_start;
            r_crc_lo    <= n_crc_lo;
            r_crc_hi    <= n_crc_hi;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_out_id  <= n_out_id;
        r_out_crc <= n_out_crc;
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_tag_id       = r_out_id;
    assign o_crc_computed = r_out_crc;

endmodule

FILE: sv/trcc_checker.sv
`timescale 1ns / 1ps
module trcc_checker
    import trcc_pkg::*;
#(
    parameter int ID_BYTES = 8
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_status,
    input logic [63:0] o_tag_id,
    input logic [15:0] o_crc_computed
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_tag_id)
                               && $stable(o_crc_computed))
        else $error("result changed while stalled");

    // a fresh result needs an input beat in the cycle before
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !$past(o_valid && i_stall) |-> $past(i_valid && !o_stall))
        else $error("result without input beat");

    // CRC ok means the received CRC was nonzero and matched
    a_ok_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_CRC_OK |-> o_crc_computed != 16'h0000)
        else $error("CRC ok with zero CRC");

    generate
        if (ID_BYTES < 8) begin : g_id_hi
            a_id_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
                o_valid |-> o_tag_id[63:8*ID_BYTES] == '0)
                else $error("identifier bits above frame length set");
        end
    endgenerate

endmodule

bind transponder_frame_crc_check trcc_checker #(.ID_BYTES(ID_BYTES)) u_trcc_checker (.*);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import trcc_pkg::*;

    localparam int ID_BYTES      = 8;
    localparam int SETTLE_CYCLES = 4;
    localparam int STALL_LIMIT   = 1000;

    typedef struct packed {
        logic [7:0] rx;
        logic       first;
    } t_rx_beat;

    typedef struct {
        t_status     status;
        logic [63:0] tag_id;
        logic [15:0] crc;
    } t_frame_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        i_frame_first = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_status;
    logic [63:0] o_tag_id;
    logic [15:0] o_crc_computed;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data = 8'h00;

    transponder_frame_crc_check #(
        .ID_BYTES(ID_BYTES)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_rx_byte     (i_rx_byte),
        .i_frame_first (i_frame_first),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_tag_id      (o_tag_id),
        .o_crc_computed(o_crc_computed),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // frame tracker state, mirrors the block
    logic [7:0]  delimiter = DELIM_RESET;
    t_pos        f_pos = '0;
    logic [15:0] f_crc = CRC_INIT;
    logic [63:0] f_id = '0;
    logic [7:0]  f_start = '0;
    logic [7:0]  f_crc_lo = '0;
    logic [7:0]  f_crc_hi = '0;

    t_rx_beat      rx_beats[$];
    t_frame_result expected_frames[$];
    int            beats_pending = 0;
    int            error_count = 0;
    int            idle_cycles = 0;
    bit            byte_taken = 1'b0;
    bit            result_taken = 1'b0;
    int            send_gap = 0;
    int            recv_wait = 0;
    bit            send_idle = 1'b1;
    bit            recv_idle = 1'b1;

    function automatic logic [15:0] kermit_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    function automatic logic [15:0] kermit_over_id(input logic [63:0] id);
        logic [15:0] c;
        c = CRC_INIT;
        for (int i = 0; i < ID_BYTES; i++)
            c = kermit_step(c, id[8*i +: 8]);
        return c;
    endfunction

    function automatic int draw_wait(input bit mode);
        return mode ? int'($urandom_range(0, 16)) : 0;
    endfunction

    task automatic frame_step(input logic [7:0] b, input logic first);
        t_frame_result r;
        if (first)
            f_pos = '0;
        if (f_pos == 0) begin
            f_start = b;
            f_crc = CRC_INIT;
            f_id = '0;
            f_pos = 1;
        end else if (f_pos <= ID_BYTES) begin
            f_id = f_id | (64'(b) << (8 * (int'(f_pos) - 1)));
            f_crc = kermit_step(f_crc, b);
            f_pos = f_pos + 1'b1;
        end else if (f_pos == ID_BYTES + 1) begin
            f_crc_lo = b;
            f_pos = f_pos + 1'b1;
        end else if (f_pos == ID_BYTES + 2) begin
            f_crc_hi = b;
            f_pos = f_pos + 1'b1;
        end else begin
            if (f_crc_lo == 8'h00 && f_crc_hi == 8'h00)
                r.status = ST_NO_TAG;
            else if (f_start != delimiter || b != delimiter)
                r.status = ST_BAD_DELIM;
            else if ({f_crc_hi, f_crc_lo} == f_crc)
                r.status = ST_CRC_OK;
            else
                r.status = ST_CRC_BAD;
            r.tag_id = f_id;
            r.crc = f_crc;
            expected_frames.push_back(r);
            f_pos = '0;
        end
    endtask

    task automatic check_result();
        t_frame_result want;
        if (expected_frames.size() == 0) begin
            $error("unexpected result beat: status %0d tag_id %h crc %h",
                   o_status, o_tag_id, o_crc_computed);
            error_count++;
        end else begin
            want = expected_frames.pop_front();
            if (o_status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, o_status);
                error_count++;
            end
            if (o_tag_id !== want.tag_id) begin
                $error("tag_id: expected %h, got %h", want.tag_id, o_tag_id);
                error_count++;
            end
            if (o_crc_computed !== want.crc) begin
                $error("crc_computed: expected %h, got %h", want.crc, o_crc_computed);
                error_count++;
            end
        end
    endtask

    // monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            byte_taken <= i_valid && !o_stall;
            result_taken <= o_valid && !i_stall;
            if (i_valid && !o_stall) begin
                frame_step(i_rx_byte, i_frame_first);
                beats_pending--;
            end
            if (o_valid && !i_stall)
                check_result();
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // byte driver
    always @(negedge i_clk) begin : drive_bytes
        t_rx_beat beat;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || byte_taken) begin
            if (send_gap != 0) begin
                i_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (rx_beats.size() != 0) begin
                beat = rx_beats.pop_front();
                i_valid <= 1'b1;
                i_rx_byte <= beat.rx;
                i_frame_first <= beat.first;
                send_gap <= draw_wait(send_idle);
                if ($urandom_range(0, 63) == 0)
                    send_idle = !send_idle;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result receiver backpressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (result_taken) begin
                recv_wait = draw_wait(recv_idle);
                if ($urandom_range(0, 15) == 0)
                    recv_idle = !recv_idle;
            end
            if (recv_wait != 0) begin
                i_stall <= 1'b1;
                if (o_valid)
                    recv_wait--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic push_beat(input logic [7:0] b, input logic first);
        t_rx_beat beat;
        beat.rx = b;
        beat.first = first;
        rx_beats.push_back(beat);
        beats_pending++;
    endtask

    task automatic push_frame(input logic [7:0] sd, input logic [63:0] id,
                              input logic [15:0] crc_field, input logic [7:0] ed,
                              input logic mark);
        push_beat(sd, mark);
        for (int i = 0; i < ID_BYTES; i++)
            push_beat(id[8*i +: 8], 1'b0);
        push_beat(crc_field[7:0], 1'b0);
        push_beat(crc_field[15:8], 1'b0);
        push_beat(ed, 1'b0);
    endtask

    task automatic push_random(input int nbytes);
        int          target;
        int          pick;
        int          n;
        bit          resync;
        logic [63:0] id;
        logic [15:0] crc_field;
        logic [7:0]  sd;
        logic [7:0]  ed;
        target = beats_pending + nbytes;
        resync = 1'b1;
        while (beats_pending < target) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                // line noise, random restart marks
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    push_beat(8'($urandom), $urandom_range(0, 3) == 0);
                resync = 1'b1;
            end else if (pick == 1) begin
                // frame cut short, the next one restarts it
                push_beat(delimiter, 1'b1);
                n = $urandom_range(1, ID_BYTES + 2);
                for (int i = 0; i < n; i++)
                    push_beat(8'($urandom), 1'b0);
                resync = 1'b1;
            end else begin
                case ($urandom_range(0, 9))
                    0: id = '0;
                    1: id = '1;
                    default: id = {$urandom, $urandom};
                endcase
                crc_field = kermit_over_id(id);
                sd = delimiter;
                ed = delimiter;
                pick = $urandom_range(0, 99);
                if (pick < 15)
                    crc_field = crc_field ^ 16'($urandom_range(1, 65535));
                else if (pick < 25)
                    crc_field = '0;
                else if (pick < 35)
                    sd = delimiter ^ 8'($urandom_range(1, 255));
                else if (pick < 45)
                    ed = delimiter ^ 8'($urandom_range(1, 255));
                else if (pick < 50) begin
                    crc_field = '0;
                    sd = 8'($urandom);
                    ed = 8'($urandom);
                end
                push_frame(sd, id, crc_field, ed, resync || $urandom_range(0, 3) != 0);
                resync = 1'b0;
            end
        end
    endtask

    // block is idle here: nothing queued, nothing outstanding
    task automatic drain();
        do @(negedge i_clk);
        while (beats_pending != 0 || expected_frames.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_delimiter(input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        delimiter = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [63:0] id;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset delimiter
        push_frame(DELIM_RESET, '1, kermit_over_id('1), DELIM_RESET, 1'b1);
        // zero CRC bytes win over wrong delimiters; no restart mark
        push_frame(8'h00, '0, 16'h0000, 8'hFF, 1'b0);
        // partial frame, then a restart with a wrong CRC
        push_beat(DELIM_RESET, 1'b1);
        for (int i = 0; i < 3; i++)
            push_beat(8'($urandom), 1'b0);
        id = {$urandom, $urandom};
        push_frame(DELIM_RESET, id, ~kermit_over_id(id), DELIM_RESET, 1'b1);
        push_random(200);
        drain();

        write_delimiter(8'h00);
        push_random(250);
        drain();

        write_delimiter(8'hFF);
        push_random(250);
        drain();

        write_delimiter(8'($urandom));
        push_random(250);
        drain();

        write_delimiter(DELIM_RESET);
        push_random(250);
        drain();

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
